>>> rtl/core/offload_bundle_header_size_check_unit_assert.svh
// Assertion macros for the offload bundle header size check unit
`ifndef OFFLOAD_BUNDLE_HEADER_SIZE_CHECK_UNIT_ASSERT_SVH
`define OFFLOAD_BUNDLE_HEADER_SIZE_CHECK_UNIT_ASSERT_SVH

// Checked on every aclk edge outside reset
`define OBHSC_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every aclk edge, reset included
`define OBHSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/obhsc_pkg.sv
// Shared types and constants for the offload bundle header size check unit
`timescale 1ns / 1ps

package obhsc_pkg;

    localparam int MAX_ENTRIES_DEF    = 256;
    localparam int MAX_ID_BYTES_DEF   = 4096;
    localparam int MARKER_BYTES       = 24;
    localparam int HEADER_BYTES       = 32;
    localparam int ENTRY_HEADER_BYTES = 24;

    localparam logic [63:0] IMAGE_LENGTH_RST = 64'h0000_0000_1000_0000;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_TOO_MANY    = 3'd2;
    localparam logic [2:0] ST_RANGE       = 3'd3;
    localparam logic [2:0] ST_ID_TOO_LONG = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] covered_size;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } verdict_t;

endpackage

>>> rtl/core/obhsc_parser.sv
// Header parse state and range checks, one byte per step
`timescale 1ns / 1ps

module obhsc_parser #(
    parameter int MAX_ENTRIES  = obhsc_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_ID_BYTES = obhsc_pkg::MAX_ID_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  obhsc_pkg::in_item_t  item,
    input  logic [63:0]          image_length,
    output obhsc_pkg::verdict_t  verdict
);

    localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W  = $clog2(MAX_ID_BYTES + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_MARKER = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_ENTRY  = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [4:0] LAST_MARKER_IDX = 5'(obhsc_pkg::MARKER_BYTES - 1);
    localparam logic [4:0] LAST_ENTRY_IDX  = 5'(obhsc_pkg::ENTRY_HEADER_BYTES - 1);
    localparam logic [64:0] HDR_END      = 65'(obhsc_pkg::HEADER_BYTES);
    localparam logic [64:0] FIRST_ENTRY  = 65'(obhsc_pkg::HEADER_BYTES
                                              + obhsc_pkg::ENTRY_HEADER_BYTES);
    localparam logic [64:0] SECOND_ENTRY = 65'(obhsc_pkg::HEADER_BYTES
                                              + 2 * obhsc_pkg::ENTRY_HEADER_BYTES);
    localparam logic [64:0] ENTRY_STEP   = 65'(obhsc_pkg::ENTRY_HEADER_BYTES);

    function automatic logic [7:0] marker_byte(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0, 5'd1, 5'd7, 5'd15, 5'd22, 5'd23: v = 8'h5f;
            5'd2:  v = 8'h43;
            5'd3:  v = 8'h4c;
            5'd4:  v = 8'h41;
            5'd5:  v = 8'h4e;
            5'd6:  v = 8'h47;
            5'd8:  v = 8'h4f;
            5'd9:  v = 8'h46;
            5'd10: v = 8'h46;
            5'd11: v = 8'h4c;
            5'd12: v = 8'h4f;
            5'd13: v = 8'h41;
            5'd14: v = 8'h44;
            5'd16: v = 8'h42;
            5'd17: v = 8'h55;
            5'd18: v = 8'h4e;
            5'd19: v = 8'h44;
            5'd20: v = 8'h4c;
            5'd21: v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] max64(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [2:0]       phase_reg, phase_next;
    logic [4:0]       idx_reg, idx_next;
    logic [55:0]      shift_reg, shift_next;
    logic [63:0]      off_reg, off_next;
    logic [63:0]      size_reg, size_next;
    logic [64:0]      ent_end_reg;
    logic [63:0]      hdr_end_reg, hdr_end_next;
    logic [64:0]      hdr48_reg, hdr48_next;
    logic [ENT_W-1:0] ents_reg, ents_next;
    logic [ID_W-1:0]  idleft_reg, idleft_next;
    logic [63:0]      largest_reg, largest_next;

    logic [2:0]  cur_phase;
    logic [4:0]  cur_idx;
    logic [7:0]  b;
    logic [63:0] field;
    logic [64:0] limit;
    logic [64:0] id_end;
    logic [64:0] hdr48_plus_id;
    logic        ee_go;
    logic [63:0] ee_largest;
    logic [64:0] ee_start;
    logic [ENT_W-1:0] ents_dec;
    logic        hit;
    logic [2:0]  st;
    logic [63:0] cov;

    assign b      = item.data_byte;
    assign field  = {b, shift_reg};
    assign limit  = {1'b0, image_length};
    assign id_end = {1'b0, hdr_end_reg} + {1'b0, field};
    assign hdr48_plus_id = hdr48_reg + {1'b0, field};
    assign ents_dec = (ents_reg == '0) ? '0 : ents_reg - ENT_W'(1);

    // A first-flagged byte restarts the parse from the marker
    assign cur_phase = item.first_byte ? PH_MARKER : phase_reg;
    assign cur_idx   = item.first_byte ? 5'd0 : idx_reg;

    always_comb begin
        phase_next   = cur_phase;
        idx_next     = cur_idx;
        shift_next   = shift_reg;
        off_next     = off_reg;
        size_next    = size_reg;
        hdr_end_next = hdr_end_reg;
        hdr48_next   = hdr48_reg;
        ents_next    = ents_reg;
        idleft_next  = idleft_reg;
        largest_next = largest_reg;
        ee_go        = 1'b0;
        ee_largest   = largest_reg;
        ee_start     = hdr48_reg;
        hit          = 1'b0;
        st           = obhsc_pkg::ST_OK;
        cov          = '0;

        for (int i = 0; i < 7; i++) begin
            if (cur_idx[2:0] == 3'(i))
                shift_next[8*i +: 8] = b;
        end

        case (cur_phase)
            PH_MARKER: begin
                if (b != marker_byte(cur_idx)) begin
                    hit = 1'b1;
                    st  = obhsc_pkg::ST_BAD_MAGIC;
                end else if (cur_idx == LAST_MARKER_IDX) begin
                    phase_next = PH_COUNT;
                    idx_next   = '0;
                end else begin
                    idx_next = cur_idx + 5'd1;
                end
            end
            PH_COUNT: begin
                if (cur_idx[2:0] != 3'd7) begin
                    idx_next = cur_idx + 5'd1;
                end else if (HDR_END > limit) begin
                    hit = 1'b1;
                    st  = obhsc_pkg::ST_RANGE;
                end else begin
                    largest_next = HDR_END[63:0];
                    if (field > 64'(MAX_ENTRIES)) begin
                        hit = 1'b1;
                        st  = obhsc_pkg::ST_TOO_MANY;
                    end else if (field == '0) begin
                        hit = 1'b1;
                        cov = HDR_END[63:0];
                    end else if (FIRST_ENTRY > limit) begin
                        hit = 1'b1;
                        st  = obhsc_pkg::ST_RANGE;
                    end else begin
                        largest_next = FIRST_ENTRY[63:0];
                        phase_next   = PH_ENTRY;
                        idx_next     = '0;
                        ents_next    = field[ENT_W-1:0];
                        hdr_end_next = FIRST_ENTRY[63:0];
                        hdr48_next   = SECOND_ENTRY;
                    end
                end
            end
            PH_ENTRY: begin
                if (cur_idx == 5'd7)
                    off_next = field;
                if (cur_idx == 5'd15)
                    size_next = field;
                if (cur_idx != LAST_ENTRY_IDX) begin
                    idx_next = cur_idx + 5'd1;
                end else if (field > 64'(MAX_ID_BYTES)) begin
                    hit = 1'b1;
                    st  = obhsc_pkg::ST_ID_TOO_LONG;
                end else if (id_end > limit || ent_end_reg > limit) begin
                    hit = 1'b1;
                    st  = obhsc_pkg::ST_RANGE;
                end else begin
                    ee_largest = max64(max64(largest_reg, id_end[63:0]),
                                       ent_end_reg[63:0]);
                    if (field == '0) begin
                        ee_go = 1'b1;
                    end else begin
                        largest_next = ee_largest;
                        phase_next   = PH_SKIP;
                        idleft_next  = field[ID_W-1:0];
                        hdr_end_next = id_end[63:0];
                        hdr48_next   = hdr48_plus_id;
                    end
                end
            end
            PH_SKIP: begin
                if (idleft_reg <= ID_W'(1))
                    ee_go = 1'b1;
                else
                    idleft_next = idleft_reg - ID_W'(1);
            end
            default: begin
                // idle or verdict given: drop the byte
            end
        endcase

        // Close an entry: finish the image, flag a range error or open the next entry header
        if (ee_go) begin
            ents_next = ents_dec;
            if (ents_dec == '0) begin
                hit = 1'b1;
                cov = ee_largest;
            end else if (ee_start > limit) begin
                hit = 1'b1;
                st  = obhsc_pkg::ST_RANGE;
            end else begin
                largest_next = max64(ee_largest, ee_start[63:0]);
                phase_next   = PH_ENTRY;
                idx_next     = '0;
                hdr_end_next = ee_start[63:0];
                hdr48_next   = ee_start + ENTRY_STEP;
            end
        end

        if (hit)
            phase_next = PH_DONE;
    end

    assign verdict.valid             = step && hit;
    assign verdict.item.status       = st;
    assign verdict.item.covered_size = cov;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= '0;
            shift_reg   <= '0;
            off_reg     <= '0;
            size_reg    <= '0;
            hdr_end_reg <= '0;
            hdr48_reg   <= '0;
            ents_reg    <= '0;
            idleft_reg  <= '0;
            largest_reg <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            shift_reg   <= shift_next;
            off_reg     <= off_next;
            size_reg    <= size_next;
            hdr_end_reg <= hdr_end_next;
            hdr48_reg   <= hdr48_next;
            ents_reg    <= ents_next;
            idleft_reg  <= idleft_next;
            largest_reg <= largest_next;
        end
    end

    // Entry image end, settled long before the last entry header byte
    always_ff @(posedge aclk) begin
        ent_end_reg <= {1'b0, off_reg} + {1'b0, size_reg};
    end

endmodule

>>> rtl/core/offload_bundle_header_size_check_unit.sv
// Top level of the offload bundle header size check unit
//
//  channel   ports                              payload
//  input     s_valid / s_ready / s_data         obhsc_pkg::in_item_t (one byte)
//  result    m_valid / m_ready / m_data         obhsc_pkg::out_item_t (verdict)
//  config    cfg_wr_en / cfg_wr_data            image_length, 64 bit
//
// One byte is taken every cycle unless the result stalls; a verdict goes from
// its byte through the input register and the parse step into the result
// register. The rate is set by the parse step, which does one 64-bit add and
// compare per range. Reset (aresetn low, synchronous) empties both registers
// and sets image_length to 256 MiB. A stalled result holds the parse step;
// s_ready then drops once the input register is full.
`timescale 1ns / 1ps

module offload_bundle_header_size_check_unit #(
    parameter int MAX_ENTRIES  = obhsc_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_ID_BYTES = obhsc_pkg::MAX_ID_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  obhsc_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output obhsc_pkg::out_item_t m_data,
    input  logic                 cfg_wr_en,
    input  logic [63:0]          cfg_wr_data
);

    logic                 in_valid_reg;
    obhsc_pkg::in_item_t  in_data_reg;
    logic                 out_valid_reg;
    obhsc_pkg::out_item_t out_data_reg;
    logic [63:0]          image_length_reg;
    logic                 step;
    obhsc_pkg::verdict_t  verdict;

    // Advance when a byte waits and the result register can take a verdict
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_length_reg <= obhsc_pkg::IMAGE_LENGTH_RST;
        end else if (cfg_wr_en) begin
            image_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_data_reg <= s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (verdict.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (verdict.valid)
            out_data_reg <= verdict.item;
    end

    obhsc_parser #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_ID_BYTES (MAX_ID_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .item         (in_data_reg),
        .image_length (image_length_reg),
        .verdict      (verdict)
    );

`include "offload_bundle_header_size_check_unit_assert.svh"

    `OBHSC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")
    `OBHSC_ASSERT_ON(a_ok_covers_header, m_valid && m_data.status == obhsc_pkg::ST_OK |-> m_data.covered_size >= 64'(obhsc_pkg::HEADER_BYTES), "ok verdict below header size")
    `OBHSC_ASSERT_ON(a_fail_zero_size, m_valid && m_data.status != obhsc_pkg::ST_OK |-> m_data.covered_size == '0, "failed verdict with nonzero size")
    `OBHSC_ASSERT_ON(a_stall_cause, !s_ready |-> m_valid && !m_ready, "input stalled without result backpressure")

endmodule
